// ----- design/irpd_pkg.sv -----
// Shared types and constants for the pulse-distance IR transmitter.
// Holds register indexes, item modes, reset values and the result layout.
// No dependencies.
`default_nettype none

package irpd_pkg;

  localparam int DEF_MAX_FRAME_BYTES = 16;

  // Configuration register indexes
  localparam logic [2:0] REG_HDR_MARK  = 3'd0;
  localparam logic [2:0] REG_HDR_SPACE = 3'd1;
  localparam logic [2:0] REG_BIT_MARK  = 3'd2;
  localparam logic [2:0] REG_ZERO_SPC  = 3'd3;
  localparam logic [2:0] REG_ONE_SPC   = 3'd4;
  localparam logic [2:0] REG_FRAME_LEN = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_HDR_MARK  = 16'd3100;
  localparam logic [15:0] RST_HDR_SPACE = 16'd1600;
  localparam logic [15:0] RST_BIT_MARK  = 16'd560;
  localparam logic [15:0] RST_ZERO_SPC  = 16'd310;
  localparam logic [15:0] RST_ONE_SPC   = 16'd1100;
  localparam logic [4:0]  RST_FRAME_LEN = 5'd14;

  // Input item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  // Result item, lowest bit first: carrier_on, busy_res, done_res
  typedef struct packed {
    logic done_res;
    logic busy_res;
    logic carrier_on;
  } irpd_res_t;

  // A duration of zero still lasts one tick
  function automatic logic [15:0] load_ticks(input logic [15:0] d);
    load_ticks = (d == 16'd0) ? 16'd1 : d;
  endfunction

endpackage

`default_nettype wire

// ----- design/irpd_frame_store.sv -----
// Frame byte store: one write port, one read port with registered read data.
// Uses no package items.
`default_nettype none

module irpd_frame_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- design/ir_pulse_distance_transmitter.sv -----
// Pulse-distance IR frame transmitter: top level with phase sequencer and
// output register with skid stage. Depends on irpd_pkg and irpd_frame_store.
//
// Usage:
//  - Input channel (in_*): one transfer per item. in_tuser carries the mode:
//    tick (one microsecond passes), frame byte write, or start. in_tdata
//    carries the byte index and value used by a write.
//  - Result channel (out_*): exactly one transfer per accepted item, in order,
//    with carrier_on, busy_res and done_res. carrier_on gates the external
//    carrier generator; done_res marks the tick on which the trailing mark
//    ends.
//  - Configuration port (cfg_*): write-only timing and frame length
//    registers, to be written while the block is idle; not enforced by the block.
//  - Throughput is one item per clock cycle while in_tready is high; each
//    result is registered before it is offered on out_*.
//  - The frame bit for the next bit space is addressed from the next bit
//    position through the store's registered read port, so ticks may
//    arrive back to back.
//  - When the receiver stalls, one further result is held in a skid stage;
//    in_tready drops only once both the output register and skid are full.
//  - Reset returns the sequencer to idle, loads the default timing and
//    empties the result buffer. Frame bytes are not cleared and must be
//    written before they are sent.
`default_nettype none

module ir_pulse_distance_transmitter
  import irpd_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES  // 1 to 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [3:0] byte_index, [11:4] byte_value, [15:12] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] carrier_on, [1] busy_res, [2] done_res, [7:3] zero
  // configuration port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int BP_W = $clog2(MAX_FRAME_BYTES * 8 + 1);
  localparam int AW   = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HMARK,
    PH_HSPACE,
    PH_BMARK,
    PH_BSPACE,
    PH_TMARK
  } phase_t;

  function automatic logic is_mark(input phase_t p);
    is_mark = (p == PH_HMARK) || (p == PH_BMARK) || (p == PH_TMARK);
  endfunction

  // configuration registers
  logic [15:0] hdr_mark_r, hdr_space_r, bit_mark_r, zero_spc_r, one_spc_r;
  logic [4:0]  frame_len_r;

  // sequencer state
  phase_t      phase_r, phase_nxt;
  logic [BP_W-1:0] bit_pos_r, bit_pos_nxt, bit_pos_inc;
  logic [15:0] ticks_left_r, ticks_left_nxt, ticks_dec;

  // result buffer
  logic      out_valid_r, skid_valid_r;
  irpd_res_t out_data_r, skid_data_r, res;

  // field views
  logic [1:0] in_mode;
  logic [3:0] in_byte_index;
  logic [7:0] in_byte_value;
  logic       in_accept, out_take;

  // frame store access
  logic          wr_en;
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          byte_ok, cur_bit;
  logic [7:0]    len_bytes;
  logic [10:0]   total_bits;

  assign in_mode       = in_tuser;
  assign in_byte_index = in_tdata[3:0];
  assign in_byte_value = in_tdata[11:4];

  assign in_tready  = !skid_valid_r;
  assign in_accept  = in_tvalid && in_tready;
  assign out_take   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};

  // Clamp the frame length to one byte at least and the store depth at most
  always_comb begin
    if (frame_len_r == 5'd0) begin
      len_bytes = 8'd1;
    end else if ({3'd0, frame_len_r} > 8'(MAX_FRAME_BYTES)) begin
      len_bytes = 8'(MAX_FRAME_BYTES);
    end else begin
      len_bytes = {3'd0, frame_len_r};
    end
  end
  assign total_bits = {len_bytes, 3'b000};

  assign bit_pos_inc = bit_pos_r + 1'b1;
  assign ticks_dec   = ticks_left_r - 16'd1;

  // rd_data holds the byte addressed by bit_pos_r; MSB of the byte goes first
  assign byte_ok = (32'(bit_pos_r[BP_W-1:3]) < MAX_FRAME_BYTES);
  assign cur_bit = byte_ok && rd_data[3'd7 - bit_pos_r[2:0]];

  always_comb begin
    phase_nxt      = phase_r;
    bit_pos_nxt    = bit_pos_r;
    ticks_left_nxt = ticks_left_r;
    res            = '0;
    wr_en          = 1'b0;
    if (in_accept) begin
      if (in_mode == MODE_TICK) begin
        if (phase_r != PH_IDLE) begin
          res.carrier_on = is_mark(phase_r);
          res.busy_res   = 1'b1;
          ticks_left_nxt = ticks_dec;
          if (ticks_dec == 16'd0) begin
            case (phase_r)
              PH_HMARK: begin
                phase_nxt      = PH_HSPACE;
                ticks_left_nxt = load_ticks(hdr_space_r);
              end
              PH_HSPACE: begin
                phase_nxt      = PH_BMARK;
                ticks_left_nxt = load_ticks(bit_mark_r);
              end
              PH_BMARK: begin
                phase_nxt      = PH_BSPACE;
                ticks_left_nxt = load_ticks(cur_bit ? one_spc_r : zero_spc_r);
              end
              PH_BSPACE: begin
                // advance to the next bit, or to the trailing mark after the last
                if (11'(bit_pos_inc) >= total_bits) begin
                  bit_pos_nxt = '0;
                  phase_nxt   = PH_TMARK;
                end else begin
                  bit_pos_nxt = bit_pos_inc;
                  phase_nxt   = PH_BMARK;
                end
                ticks_left_nxt = load_ticks(bit_mark_r);
              end
              default: begin
                phase_nxt    = PH_IDLE;
                bit_pos_nxt  = '0;
                res.done_res = 1'b1;
              end
            endcase
          end
        end
      end else begin
        // writes and starts take effect only while idle
        if (phase_r == PH_IDLE) begin
          if (in_mode == MODE_WRITE) begin
            wr_en = (32'(in_byte_index) < MAX_FRAME_BYTES);
          end else if (in_mode == MODE_START) begin
            phase_nxt      = PH_HMARK;
            bit_pos_nxt    = '0;
            ticks_left_nxt = load_ticks(hdr_mark_r);
          end
        end
        res.carrier_on = is_mark(phase_nxt);
        res.busy_res   = (phase_nxt != PH_IDLE);
      end
    end
  end

  // address the store from the next bit position so its byte is ready in time
  assign rd_addr = AW'(bit_pos_nxt[BP_W-1:3]);

  irpd_frame_store #(
    .DEPTH (MAX_FRAME_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_byte_index)),
    .wr_data (in_byte_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mark_r   <= RST_HDR_MARK;
      hdr_space_r  <= RST_HDR_SPACE;
      bit_mark_r   <= RST_BIT_MARK;
      zero_spc_r   <= RST_ZERO_SPC;
      one_spc_r    <= RST_ONE_SPC;
      frame_len_r  <= RST_FRAME_LEN;
      phase_r      <= PH_IDLE;
      bit_pos_r    <= '0;
      ticks_left_r <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HDR_MARK:  hdr_mark_r  <= cfg_wdata;
          REG_HDR_SPACE: hdr_space_r <= cfg_wdata;
          REG_BIT_MARK:  bit_mark_r  <= cfg_wdata;
          REG_ZERO_SPC:  zero_spc_r  <= cfg_wdata;
          REG_ONE_SPC:   one_spc_r   <= cfg_wdata;
          REG_FRAME_LEN: frame_len_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end

      phase_r      <= phase_nxt;
      bit_pos_r    <= bit_pos_nxt;
      ticks_left_r <= ticks_left_nxt;

      // output register refills from skid first, then from the new result
      if (out_valid_r && !out_take) begin
        if (in_accept) begin
          skid_valid_r <= 1'b1;
          skid_data_r  <= res;
        end
      end else if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
        out_data_r  <= res;
      end
    end
  end

  // skid holds a result only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage valid while output register empty");

  // the frame end is reported only while a frame is in progress
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> out_tdata[1])
    else $error("done without busy");

  // carrier is never enabled outside a frame
  a_carrier_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> out_tdata[1])
    else $error("carrier on while not busy");

  // the tick that ends the trailing mark returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && res.done_res) |=> (phase_r == PH_IDLE && bit_pos_r == '0))
    else $error("sequencer not idle after frame end");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for the pulse-distance IR frame transmitter.
// Drives item and register traffic, predicts or tables every result and
// compares it on the result stream. Depends on irpd_pkg and the block RTL.
`default_nettype none

module tb
  import irpd_pkg::*;
;

  localparam int STORE_DEPTH = DEF_MAX_FRAME_BYTES;
  localparam int QUIET_LIMIT = 1000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 48;    // long receiver hold-off that fills the block

  // Item mode that the block ignores
  localparam logic [1:0] MODE_NONE = 2'd3;
  // Register indexes beyond the implemented set
  localparam logic [2:0] REG_SPARE0 = 3'd6;
  localparam logic [2:0] REG_SPARE1 = 3'd7;

  localparam irpd_res_t LINE_IDLE = '{done_res: 1'b0, busy_res: 1'b0, carrier_on: 1'b0};
  localparam irpd_res_t LINE_MARK = '{done_res: 1'b0, busy_res: 1'b1, carrier_on: 1'b1};

  typedef enum logic [2:0] {
    PD_IDLE, PD_HDR_MARK, PD_HDR_SPACE, PD_BIT_MARK, PD_BIT_SPACE, PD_TRAIL_MARK
  } pd_phase_t;

  typedef struct {
    logic [1:0] mode;
    logic [3:0] idx;
    logic [7:0] val;
    bit         typed;  // use res below instead of the prediction
    irpd_res_t  res;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_wdata  = '0;

  // Predicted line behavior: timing registers
  logic [15:0] hdr_mark_len   = RST_HDR_MARK;
  logic [15:0] hdr_space_len  = RST_HDR_SPACE;
  logic [15:0] bit_mark_len   = RST_BIT_MARK;
  logic [15:0] zero_space_len = RST_ZERO_SPC;
  logic [15:0] one_space_len  = RST_ONE_SPC;
  logic [4:0]  frame_len      = RST_FRAME_LEN;
  // Predicted line behavior: sequencer and byte store
  pd_phase_t   tx_phase = PD_IDLE;
  int          tx_bit   = 0;
  logic [15:0] tx_left  = '0;
  logic [7:0]  frame_mem [STORE_DEPTH];

  irpd_res_t   line_expected [$];
  int          mismatches   = 0;
  int          results_seen = 0;
  int          items_sent   = 0;
  int          quiet_cycles = 0;
  bit          full_rate    = 1'b0;  // both sides drop their random gaps while set

  // Opening table: idle behavior, store fill, start and busy filtering
  stim_row_t opening_rows [23] = '{
    '{MODE_TICK,  4'd0,  8'h00, 1'b1, LINE_IDLE},   // tick while idle changes nothing
    '{MODE_NONE,  4'd15, 8'hFF, 1'b1, LINE_IDLE},   // unused mode while idle
    '{MODE_WRITE, 4'd0,  8'hFF, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd1,  8'h00, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd2,  8'hA5, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd3,  8'h5A, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd4,  8'h81, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd5,  8'h7E, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd6,  8'h0F, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd7,  8'hF0, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd8,  8'h33, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd9,  8'hCC, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd10, 8'h01, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd11, 8'h80, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd12, 8'h96, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd13, 8'h69, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd14, 8'hFE, 1'b1, LINE_IDLE},
    '{MODE_WRITE, 4'd15, 8'h7F, 1'b1, LINE_IDLE},
    '{MODE_START, 4'd9,  8'h3C, 1'b1, LINE_MARK},   // header mark in force at once
    '{MODE_START, 4'd3,  8'hC3, 1'b1, LINE_MARK},   // start while busy is dropped
    '{MODE_WRITE, 4'd0,  8'h00, 1'b1, LINE_MARK},   // write while busy is dropped
    '{MODE_NONE,  4'd0,  8'h00, 1'b1, LINE_MARK},   // unused mode while busy
    '{MODE_TICK,  4'd7,  8'h55, 1'b0, LINE_IDLE}
  };

  ir_pulse_distance_transmitter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Line predictor
  // ---------------------------------------------------------------------

  // A zero duration still holds its level for one tick
  function automatic logic [15:0] at_least_one(input logic [15:0] d);
    return (d == 16'd0) ? 16'd1 : d;
  endfunction

  function automatic logic carrier_phase(input pd_phase_t p);
    return (p == PD_HDR_MARK || p == PD_BIT_MARK || p == PD_TRAIL_MARK);
  endfunction

  // Frame length is clamped to the store and read live
  function automatic int frame_bits();
    int n;
    n = frame_len;
    if (n == 0) n = 1;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    return n * 8;
  endfunction

  // Advance the predicted line by one item and return what the block shows
  function automatic irpd_res_t line_step(input logic [1:0] mode, input logic [3:0] idx,
                                          input logic [7:0] val);
    irpd_res_t  r;
    logic [7:0] cur;
    r = LINE_IDLE;
    if (mode == MODE_TICK) begin
      if (tx_phase != PD_IDLE) begin
        // Tick shows the phase in force before it is counted
        r.carrier_on = carrier_phase(tx_phase);
        r.busy_res = 1'b1;
        tx_left = tx_left - 16'd1;
        if (tx_left == 16'd0) begin
          case (tx_phase)
            PD_HDR_MARK: begin
              tx_phase = PD_HDR_SPACE;
              tx_left = at_least_one(hdr_space_len);
            end
            PD_HDR_SPACE: begin
              tx_phase = PD_BIT_MARK;
              tx_left = at_least_one(bit_mark_len);
            end
            PD_BIT_MARK: begin
              // Most significant bit of each byte goes first
              cur = frame_mem[tx_bit / 8];
              tx_phase = PD_BIT_SPACE;
              tx_left = at_least_one(cur[7 - (tx_bit % 8)] ? one_space_len : zero_space_len);
            end
            PD_BIT_SPACE: begin
              tx_bit++;
              if (tx_bit >= frame_bits()) begin
                tx_bit = 0;
                tx_phase = PD_TRAIL_MARK;
              end else begin
                tx_phase = PD_BIT_MARK;
              end
              tx_left = at_least_one(bit_mark_len);
            end
            default: begin
              // Trailing mark ends: flag it on this tick, idle from the next
              tx_phase = PD_IDLE;
              tx_bit = 0;
              r.done_res = 1'b1;
            end
          endcase
        end
      end
    end else begin
      // Writes and starts only take effect while idle
      if (tx_phase == PD_IDLE) begin
        if (mode == MODE_WRITE) begin
          frame_mem[idx] = val;
        end else if (mode == MODE_START) begin
          tx_phase = PD_HDR_MARK;
          tx_bit = 0;
          tx_left = at_least_one(hdr_mark_len);
        end
      end
      r.carrier_on = carrier_phase(tx_phase);
      r.busy_res = (tx_phase != PD_IDLE);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then log its expectation.
  // Enter and leave on a falling edge; in_tvalid stays high on return.
  task automatic send_item(input logic [1:0] mode, input logic [3:0] idx,
                           input logic [7:0] val, input bit typed = 1'b0,
                           input irpd_res_t typed_res = LINE_IDLE);
    int        gap;
    irpd_res_t r;
    gap = full_rate ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0000, val, idx};
    do @(posedge clk); while (!in_tready);
    r = line_step(mode, idx, val);
    line_expected.push_back(typed ? typed_res : r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  // Tick until the predicted frame is over
  task automatic finish_frame();
    while (tx_phase != PD_IDLE) send_tick();
  endtask

  // Bring the block to rest: frame over, every result back, pipeline drained
  task automatic quiesce();
    finish_frame();
    in_tvalid <= 1'b0;
    while (line_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    case (index)
      REG_HDR_MARK:  hdr_mark_len = value;
      REG_HDR_SPACE: hdr_space_len = value;
      REG_BIT_MARK:  bit_mark_len = value;
      REG_ZERO_SPC:  zero_space_len = value;
      REG_ONE_SPC:   one_space_len = value;
      REG_FRAME_LEN: frame_len = value[4:0];
      default: ;
    endcase
  endtask

  task automatic write_timing(input logic [15:0] hm, input logic [15:0] hs,
                              input logic [15:0] bm, input logic [15:0] zs,
                              input logic [15:0] os, input logic [15:0] fl);
    write_reg(REG_HDR_MARK, hm);
    write_reg(REG_HDR_SPACE, hs);
    write_reg(REG_BIT_MARK, bm);
    write_reg(REG_ZERO_SPC, zs);
    write_reg(REG_ONE_SPC, os);
    write_reg(REG_FRAME_LEN, fl);
    cfg_we <= 1'b0;
  endtask

  // Short durations keep frames brief; 0 and 1 stay common
  function automatic logic [15:0] pick_len(input bit tiny);
    int r;
    r = $urandom_range(0, 9);
    if (tiny || r < 2) return 16'($urandom_range(0, 1));
    return 16'($urandom_range(2, 5));
  endfunction

  // A full frame with random content: some writes, a start, then ticks with
  // stray starts, writes and unused modes mixed in while busy
  task automatic random_frame();
    int nw;
    nw = $urandom_range(0, 3);
    repeat (nw) send_item(MODE_WRITE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    send_item(MODE_START, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    while (tx_phase != PD_IDLE) begin
      case ($urandom_range(0, 11))
        0: send_item(MODE_START, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        1: send_item(MODE_WRITE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        2: send_item(MODE_NONE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        default: send_tick();
      endcase
    end
  endtask

  int phase_lens [3] = '{1, 2, 3};

  initial begin
    int  goal;
    bit  tiny;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short timing and a two-byte frame keep the opening frame brief
    write_timing(16'h0003, 16'h0002, 16'h0001, 16'h0001, 16'h0002, 16'h0002);

    // Opening table, then run the frame out at full rate
    foreach (opening_rows[i]) begin
      send_item(opening_rows[i].mode, opening_rows[i].idx, opening_rows[i].val,
                opening_rows[i].typed, opening_rows[i].res);
    end
    full_rate = 1'b1;
    finish_frame();
    full_rate = 1'b0;

    // Short header, zero-length bit mark and zero space, frame length field of zero
    quiesce();
    write_timing(16'h0004, 16'h0003, 16'h0000, 16'h0000, 16'h0001, 16'hFFE0);
    full_rate = 1'b1;
    send_item(MODE_START, 4'd0, 8'h00);
    finish_frame();
    full_rate = 1'b0;

    // Frame length field at its top, clamped to the whole store; zero durations
    quiesce();
    write_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    full_rate = 1'b1;
    send_item(MODE_START, 4'd0, 8'h00);
    finish_frame();
    full_rate = 1'b0;

    // Random phases, each with its own timing
    foreach (phase_lens[k]) begin
      quiesce();
      tiny = (phase_lens[k] > 1);
      if (k == 0) begin
        write_reg(REG_SPARE0, 16'($urandom_range(0, 65535)));
        write_reg(REG_SPARE1, 16'($urandom_range(0, 65535)));
      end
      write_timing(pick_len(tiny), pick_len(tiny), pick_len(tiny), pick_len(tiny),
                   pick_len(tiny), {11'($urandom_range(0, 2047)), 5'(phase_lens[k])});
      goal = items_sent + 40;
      while (items_sent < goal) begin
        if ($urandom_range(0, 9) < 8) begin
          random_frame();
        end else begin
          send_item(($urandom_range(0, 1) != 0) ? MODE_TICK : MODE_NONE,
                    4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end
      end
    end

    // Drain and let the pipeline settle
    in_tvalid <= 1'b0;
    while (line_expected.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d: %s expected %b, got %b", results_seen, name, want, got);
      end
    end
  endtask

  // Stall at random between results; every so often hold off long enough
  // that the output stage and skid fill and in_tready drops
  initial begin
    int        gap;
    irpd_res_t want;
    irpd_res_t got;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (results_seen % 128 == 100) gap = HOLD_CYCLES;
      else gap = full_rate ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = irpd_res_t'(out_tdata[2:0]);
      if (line_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: unexpected transfer %b", results_seen, out_tdata);
        end
      end else begin
        want = line_expected.pop_front();
        check_field("carrier_on", want.carrier_on, got.carrier_on);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
      end
      results_seen++;
      @(negedge clk);
    end
  end

  // Watchdog: any transfer or register write counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire
